[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text console block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // item kinds
  localparam logic [1:0] KIND_CURSOR = 2'd0;
  localparam logic [1:0] KIND_AT     = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // control characters
  localparam logic [7:0] CH_BELL  = 8'd7;
  localparam logic [7:0] CH_BACK  = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // port field widths
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int ROWSEL_W = 5;
  localparam int COLSEL_W = 7;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_WAIT,
    S_SWEEP,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic accept;      // capture the incoming request
    logic calc;        // resolve position, new cursor and target address
    logic exec;        // first memory access
    logic wait_st;     // read data back: backspace write or cell capture
    logic sweep_run;   // memory sweep (clear or scroll)
    logic sweep_zero;  // sweep writes zeros only
    logic load_out;    // load the output register
  } cmd_t;

  typedef struct packed {
    logic need_wait;
    logic need_scroll;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console: clear pass, per-request steps, scroll sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_run  = 1'b1;
        cmd_o.sweep_zero = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_wait)        state_d = S_WAIT;
        else if (sts_i.need_scroll) state_d = S_SWEEP;
        else                        state_d = S_DONE;
      end
      S_WAIT: begin
        cmd_o.wait_st = 1'b1;
        if (sts_i.need_scroll) state_d = S_SWEEP;
        else                   state_d = S_DONE;
      end
      S_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `TCW_ASSERT_NEXT(a_accept_calc, clk_i, rst_ni, cmd_o.accept, state_q == S_CALC, "accept not followed by calc")
  `TCW_ASSERT_IMPL(a_sweep_entry, clk_i, rst_ni, (state_q == S_SWEEP) && ($past(state_q) != S_SWEEP), ($past(state_q) == S_EXEC) || ($past(state_q) == S_WAIT), "scroll entered from wrong step")
  `TCW_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, cmd_o.load_out, (state_q == S_IDLE) && !cmd_o.sweep_run, "result load did not return to idle")

endmodule

[rtl/core/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, request registers, cell store access, scroll sweep, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [BYTE_W-1:0]   char_code_i,
  input  logic [BYTE_W-1:0]   attr_i,
  input  logic [ROWSEL_W-1:0] row_sel_i,
  input  logic [COLSEL_W-1:0] col_sel_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CURSOR_W-1:0] cursor_cell_o,
  output logic                beep_o,
  output logic                scrolled_o,
  output logic [BYTE_W-1:0]   read_char_o,
  output logic [BYTE_W-1:0]   read_attr_o
);

  localparam int CELLS    = ROWS * COLS;
  localparam int LAST_ROW = CELLS - COLS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLS);
  localparam int SW       = $clog2(CELLS + 1);

  // request registers
  logic [KIND_W-1:0] kind_q;
  logic [BYTE_W-1:0] ch_q, attr_q;
  logic [RW-1:0]     rsel_q, rsel_d;
  logic [CW-1:0]     csel_q, csel_d;

  // cursor and resolved access
  logic [RW-1:0]       cur_r_q;
  logic [CW-1:0]       cur_c_q;
  logic [CURSOR_W-1:0] curlin_q;
  logic [AW-1:0]       addr_q, addr_d;
  logic                wr_q, bs_q, rd_q, beep_q, scroll_q;
  logic                wr_d, bs_d, rd_d, beep_d, scroll_d;
  logic [BYTE_W-1:0]   rch_q, rat_q;

  logic [RW-1:0] pr;
  logic [CW-1:0] pc, tc, nc;
  logic [RW:0]   nr;

  // sweep
  logic [SW-1:0] sweep_q;
  logic          sweep_last;

  // memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // output register
  logic                out_valid_q;
  logic [CURSOR_W-1:0] out_cursor_q;
  logic                out_beep_q, out_scr_q;
  logic [BYTE_W-1:0]   out_rch_q, out_rat_q;

  // saturate positioned row / column on capture
  always_comb begin
    if (32'(row_sel_i) >= ROWS) rsel_d = RW'(ROWS - 1);
    else                        rsel_d = RW'(row_sel_i);
    if (32'(col_sel_i) >= COLS) csel_d = CW'(COLS - 1);
    else                        csel_d = CW'(col_sel_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      ch_q   <= char_code_i;
      attr_q <= attr_i;
      rsel_q <= rsel_d;
      csel_q <= csel_d;
    end
  end

  // print rules
  always_comb begin
    if (kind_q == KIND_CURSOR) begin
      pr = cur_r_q;
      pc = cur_c_q;
    end else begin
      pr = rsel_q;
      pc = csel_q;
    end
    nr     = {1'b0, cur_r_q};
    nc     = cur_c_q;
    tc     = pc;
    wr_d   = 1'b0;
    bs_d   = 1'b0;
    rd_d   = 1'b0;
    beep_d = 1'b0;
    case (kind_q)
      KIND_CURSOR, KIND_AT: begin
        nr = {1'b0, pr};
        nc = pc;
        case (ch_q)
          CH_BELL: beep_d = 1'b1;
          CH_BACK: begin
            if (pc != '0) begin
              nc   = pc - CW'(1);
              tc   = pc - CW'(1);
              bs_d = 1'b1;
            end
          end
          CH_LF: nr = {1'b0, pr} + (RW + 1)'(1);
          CH_CR: nc = '0;
          default: begin
            wr_d = 1'b1;
            if (pc == CW'(COLS - 1)) begin
              nc = '0;
              nr = {1'b0, pr} + (RW + 1)'(1);
            end else begin
              nc = pc + CW'(1);
            end
          end
        endcase
      end
      KIND_READ: rd_d = 1'b1;
      default: ;
    endcase
    scroll_d = (nr == (RW + 1)'(ROWS));
    if (scroll_d) nr = (RW + 1)'(ROWS - 1);
    addr_d = AW'(32'(pr) * COLS + 32'(tc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_r_q  <= '0;
      cur_c_q  <= '0;
      curlin_q <= '0;
      wr_q     <= 1'b0;
      bs_q     <= 1'b0;
      rd_q     <= 1'b0;
      beep_q   <= 1'b0;
      scroll_q <= 1'b0;
    end else begin
      curlin_q <= CURSOR_W'(32'(cur_r_q) * COLS + 32'(cur_c_q));
      if (cmd_i.calc) begin
        cur_r_q  <= RW'(nr);
        cur_c_q  <= nc;
        wr_q     <= wr_d;
        bs_q     <= bs_d;
        rd_q     <= rd_d;
        beep_q   <= beep_d;
        scroll_q <= scroll_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q <= addr_d;
      rch_q  <= '0;
      rat_q  <= '0;
    end else if (cmd_i.wait_st && rd_q) begin
      rch_q <= ram_rdata[BYTE_W-1:0];
      rat_q <= ram_rdata[CELL_W-1:BYTE_W];
    end
  end

  // sweep counter: step k reads cell k+COLS and writes cell k-1
  assign sweep_last = (32'(sweep_q) == CELLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_run) begin
      sweep_q <= sweep_last ? '0 : sweep_q + SW'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = addr_q;
    if (cmd_i.sweep_run) begin
      ram_raddr = (32'(sweep_q) < LAST_ROW) ? AW'(32'(sweep_q) + COLS) : '0;
      ram_we    = (sweep_q != '0);
      ram_waddr = AW'(32'(sweep_q) - 1);
      if (!cmd_i.sweep_zero && (32'(sweep_q) - 1 < LAST_ROW)) ram_wdata = ram_rdata;
    end else if (cmd_i.exec) begin
      ram_we    = wr_q;
      ram_wdata = {attr_q, ch_q};
    end else if (cmd_i.wait_st) begin
      ram_we    = bs_q;
      ram_wdata = {ram_rdata[CELL_W-1:BYTE_W], CH_SPACE};
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cursor_q <= curlin_q;
      out_beep_q   <= beep_q;
      out_scr_q    <= scroll_q;
      out_rch_q    <= rch_q;
      out_rat_q    <= rat_q;
    end
  end

  assign sts_o.need_wait   = bs_q | rd_q;
  assign sts_o.need_scroll = scroll_q;
  assign sts_o.sweep_last  = sweep_last;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign cursor_cell_o = out_cursor_q;
  assign beep_o        = out_beep_q;
  assign scrolled_o    = out_scr_q;
  assign read_char_o   = out_rch_q;
  assign read_attr_o   = out_rat_q;

  `TCW_ASSERT_IMPL(a_cur_row, clk_i, rst_ni, 1'b1, (32'(cur_r_q) < ROWS) && (32'(cur_c_q) < COLS), "cursor out of range")
  `TCW_ASSERT_IMPL(a_sweep_idle, clk_i, rst_ni, !cmd_i.sweep_run, sweep_q == '0, "sweep counter moved outside a sweep")

endmodule

[rtl/core/text_console_cell_writer.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Teletype-style text console over a ROWS x COLS store of char/style cells.
//
// Input stream (s_axis): one request per transfer. tuser carries the kind
// (print at cursor, print at row/col, read cell); tdata carries char, style
// byte, row and column. Output stream (m_axis): one result per request with
// the cursor after the request, bell and scroll flags, and the read cell.
// Steps: a request is accepted, resolved (calc) and applied to the cell
// memory port (exec); backspace and reads add a step that reads the cell back
// (backspace writes a blank over it, a read captures it), and the result
// register is loaded last. A print that runs off the end of the screen adds
// a scroll sweep: one cell is copied up per cycle through the dual-port cell
// RAM, last row zeroed in the same sweep.
// Flow: a new request is taken only after the previous result is loaded,
// in the cycle after the load, even if that result is still waiting.
// Reset: cursor to zero and a clearing pass zeroes the store; s_axis_tready
// stays low until it ends. Receiver stall: the result waits in the output
// register; a second result holds the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module text_console_cell_writer
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // char_code[7:0], attr[15:8], row_sel[20:16],
                                     // col_sel[27:21], zero pad [31:28]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // cursor_cell[10:0], beep[11], scrolled[12],
                                     // read_char[20:13], read_attr[28:21], zero [31:29]
);

  cmd_t cmd;
  sts_t sts;

  logic [CURSOR_W-1:0] cursor_cell;
  logic                beep, scrolled;
  logic [BYTE_W-1:0]   read_char, read_attr;

  // sequencer: clear pass after reset, then calc / exec / wait / scroll / done
  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: unpack request fields straight from the bus
  tcw_datapath #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (s_axis_tuser),
    .char_code_i  (s_axis_tdata[7:0]),
    .attr_i       (s_axis_tdata[15:8]),
    .row_sel_i    (s_axis_tdata[20:16]),
    .col_sel_i    (s_axis_tdata[27:21]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .cursor_cell_o(cursor_cell),
    .beep_o       (beep),
    .scrolled_o   (scrolled),
    .read_char_o  (read_char),
    .read_attr_o  (read_attr)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {3'b000, read_attr, read_char, scrolled, beep, cursor_cell};

endmodule

[tb/text_console_cell_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_checker
// Watches the request and result streams of the text console. It keeps its
// own copy of the screen and cursor, works out each expected result when a
// request is accepted, and compares results in order as they are taken.
// ----------------------------------------------------------------------------
module text_console_cell_checker
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [31:0] req_data_i,
  input  logic [1:0]  req_kind_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [31:0] res_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          print_cnt_o,
  output int          read_cnt_o,
  output int          scroll_cnt_o,
  output int          bell_cnt_o,
  output int          spare_cnt_o
);

  localparam int CELLS     = ROWS * COLS;
  localparam int MAX_LINES = 100;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic                beep;
    logic                scrolled;
    logic [BYTE_W-1:0]   read_char;
    logic [BYTE_W-1:0]   read_attr;
  } console_result_t;

  logic [CELL_W-1:0] screen [CELLS];
  int                cursor_pos;
  console_result_t   expected_q [$];
  int                i;

  // out-of-range row or column clamps to the last one
  function automatic int cell_index(input logic [ROWSEL_W-1:0] row,
                                    input logic [COLSEL_W-1:0] col);
    int r;
    int c;
    r = (row >= ROWS) ? ROWS - 1 : int'(row);
    c = (col >= COLS) ? COLS - 1 : int'(col);
    return r * COLS + c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (fail_cnt_o < MAX_LINES)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_cnt_o++;
  endtask

  task automatic scroll_screen();
    int k;
    for (k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
    for (k = CELLS - COLS; k < CELLS; k++) screen[k] = '0;
  endtask

  task automatic predict_console(input logic [1:0] kind, input logic [31:0] data);
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] style;
    int                pos;
    console_result_t   res;
    ch    = data[7:0];
    style = data[15:8];
    res   = '0;
    case (kind)
      KIND_READ: begin
        pos           = cell_index(data[20:16], data[27:21]);
        res.read_char = screen[pos][7:0];
        res.read_attr = screen[pos][15:8];
        read_cnt_o++;
      end
      KIND_CURSOR, KIND_AT: begin
        pos = (kind == KIND_AT) ? cell_index(data[20:16], data[27:21]) : cursor_pos;
        if (pos >= CELLS) pos = 0;
        case (ch)
          CH_BELL: begin
            res.beep = 1'b1;
            bell_cnt_o++;
          end
          CH_BACK: begin
            // nothing to rub out at the start of a line
            if (pos % COLS != 0) begin
              pos--;
              screen[pos][7:0] = CH_SPACE;
            end
          end
          CH_LF: pos += COLS;
          CH_CR: pos -= pos % COLS;
          default: begin
            screen[pos] = {style, ch};
            pos++;
          end
        endcase
        if (pos >= CELLS) begin
          scroll_screen();
          pos -= COLS;
          res.scrolled = 1'b1;
          scroll_cnt_o++;
        end
        cursor_pos = pos;
        print_cnt_o++;
      end
      default: spare_cnt_o++;
    endcase
    res.cursor_cell = cursor_pos[CURSOR_W-1:0];
    expected_q.push_back(res);
  endtask

  task automatic check_console(input logic [31:0] data);
    console_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing expected", '0, data);
      return;
    end
    want = expected_q.pop_front();
    if (data[10:0] !== want.cursor_cell)
      report_mismatch("cursor_cell", 32'(want.cursor_cell), 32'(data[10:0]));
    if (data[11] !== want.beep)
      report_mismatch("beep", 32'(want.beep), 32'(data[11]));
    if (data[12] !== want.scrolled)
      report_mismatch("scrolled", 32'(want.scrolled), 32'(data[12]));
    if (data[20:13] !== want.read_char)
      report_mismatch("read_char", 32'(want.read_char), 32'(data[20:13]));
    if (data[28:21] !== want.read_attr)
      report_mismatch("read_attr", 32'(want.read_attr), 32'(data[28:21]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (i = 0; i < CELLS; i++) screen[i] = '0;
      cursor_pos = 0;
      expected_q.delete();
      fail_cnt_o   = 0;
      pending_o    = 0;
      print_cnt_o  = 0;
      read_cnt_o   = 0;
      scroll_cnt_o = 0;
      bell_cnt_o   = 0;
      spare_cnt_o  = 0;
    end else begin
      // older result first: it can never belong to a request taken this edge
      if (res_valid_i && res_ready_i) check_console(res_data_i);
      if (req_valid_i && req_ready_i) predict_console(req_kind_i, req_data_i);
      pending_o = expected_q.size();
    end
  end

endmodule

[tb/text_console_cell_writer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Drives the text console with a short directed run of corner cases, then
// with random console traffic (text, control characters, positioned prints,
// cell reads and the unused kind), under random gaps on both streams and one
// long receiver hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  // tuser value that the block ignores
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1925;
  // worst case is a scroll sweep on every request, plus the reset clearing
  // pass; this limit is several times that
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int HOLD_CYCLES  = 400;   // receiver hold-off, fills the block up
  localparam int HOLD_AT_ITEM = 1000;
  localparam int QUIET_FROM   = 600;   // no gaps or stalls on either side
  localparam int QUIET_TO     = 900;
  localparam int TAIL_CYCLES  = 40;    // watch for stray results after the last one

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int fail_cnt;
  int pending;
  int print_cnt;
  int read_cnt;
  int scroll_cnt;
  int bell_cnt;
  int spare_cnt;

  int   cycle_cnt = 0;
  int   item_no   = 0;   // requests accepted so far
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #5 clk_i = ~clk_i;

  text_console_cell_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  text_console_cell_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_kind_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .print_cnt_o (print_cnt),
    .read_cnt_o  (read_cnt),
    .scroll_cnt_o(scroll_cnt),
    .bell_cnt_o  (bell_cnt),
    .spare_cnt_o (spare_cnt)
  );

  function automatic logic in_quiet_window();
    return item_no >= QUIET_FROM && item_no < QUIET_TO;
  endfunction

  // Watchdog: the run must finish well inside the limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run stopped at %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet window, and one long hold-off once the
  // stimulus asks for it. One assignment to tready per falling edge.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (in_quiet_window()) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 7);
    end
  end

  // Offer one request and hold it until taken. Data changes only on falling
  // edges; tready is looked at on the rising edge it counts for.
  task automatic send_request(input logic [1:0] kind, input logic [7:0] ch,
                              input logic [7:0] attr, input logic [4:0] row,
                              input logic [6:0] col);
    @(negedge clk_i);
    while (!in_quiet_window() && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, col, row, attr, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_no++;
    if (item_no == HOLD_AT_ITEM) hold_req = 1'b1;
  endtask

  // Corner cases: clamping, scroll at the last cell and on a line feed,
  // backspace at and away from column 0, bell, return, unused kind, and the
  // extreme character and style bytes.
  task automatic run_directed();
    send_request(KIND_READ,   8'h00,    8'h00, 5'd0,  7'd0);
    send_request(KIND_CURSOR, 8'h41,    8'hFF, 5'd0,  7'd0);
    send_request(KIND_AT,     8'hFF,    8'hAA, 5'd31, 7'd127);  // last cell, scrolls
    send_request(KIND_READ,   8'h00,    8'h00, 5'd31, 7'd127);  // zeroed last row
    send_request(KIND_READ,   8'h00,    8'h00, 5'd23, 7'd79);   // moved up one row
    send_request(KIND_CURSOR, CH_BELL,  8'h55, 5'd0,  7'd0);
    send_request(KIND_CURSOR, CH_BACK,  8'h00, 5'd0,  7'd0);    // start of line: no-op
    send_request(KIND_CURSOR, 8'h42,    8'h3C, 5'd0,  7'd0);
    send_request(KIND_CURSOR, CH_BACK,  8'h00, 5'd0,  7'd0);    // blanks, keeps style
    send_request(KIND_READ,   8'h00,    8'h00, 5'd24, 7'd0);
    send_request(KIND_CURSOR, CH_LF,    8'h00, 5'd0,  7'd0);    // bottom row: scrolls
    send_request(KIND_READ,   8'h00,    8'h00, 5'd23, 7'd0);
    send_request(KIND_AT,     8'h00,    8'h00, 5'd2,  7'd40);
    send_request(KIND_CURSOR, CH_CR,    8'h00, 5'd0,  7'd0);
    send_request(KIND_SPARE,  8'hFF,    8'hFF, 5'd31, 7'd127);
    send_request(KIND_AT,     CH_LF,    8'h00, 5'd0,  7'd5);
    send_request(KIND_AT,     CH_CR,    8'h00, 5'd10, 7'd40);
    send_request(KIND_AT,     CH_BELL,  8'h00, 5'd5,  7'd5);
    send_request(KIND_AT,     CH_BACK,  8'h00, 5'd3,  7'd0);
    send_request(KIND_AT,     CH_BACK,  8'h00, 5'd3,  7'd10);
    send_request(KIND_READ,   8'h00,    8'h00, 5'd3,  7'd9);
    send_request(KIND_READ,   8'h00,    8'h00, 5'd0,  7'd127);
    send_request(KIND_READ,   8'h00,    8'h00, 5'd31, 7'd0);
    send_request(KIND_CURSOR, 8'h7F,    8'h80, 5'd0,  7'd0);
    send_request(KIND_AT,     CH_LF,    8'h00, 5'd24, 7'd79);   // past the end
  endtask

  // Mostly text with a sprinkling of control characters, like a terminal.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return CH_LF;
    if (r < 8) return CH_CR;
    if (r < 11) return CH_BACK;
    if (r < 13) return CH_BELL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Rows and columns mostly on screen, some past the edge to hit clamping.
  function automatic logic [4:0] pick_row();
    if ($urandom_range(0, 99) < 80) return 5'($urandom_range(0, ROWS - 1));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [6:0] pick_col();
    if ($urandom_range(0, 99) < 80) return 7'($urandom_range(0, COLS - 1));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic run_random();
    int         n;
    int         r;
    logic [1:0] kind;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 60) kind = KIND_CURSOR;
      else if (r < 72) kind = KIND_AT;
      else if (r < 97) kind = KIND_READ;
      else kind = KIND_SPARE;
      send_request(kind, pick_char(), 8'($urandom_range(0, 255)), pick_row(), pick_col());
    end
  endtask

  initial begin
    // hold reset, then release it; the block then clears its store by itself
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // every request yields one result: drain, then watch for strays
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests in %0d cycles: %0d prints (%0d scrolls, %0d bells)",
             item_no, cycle_cnt, print_cnt, scroll_cnt, bell_cnt);
    $display("  %0d cell reads, %0d unused-kind requests, %0d mismatches",
             read_cnt, spare_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
